/* hdl/i2cm_pkg.sv */
// shared types and constants for the i2c master transaction engine
// no dependencies; imported by every module of the block
`default_nettype none

package i2cm_pkg;

  // default byte queue depth for the top level parameter
  localparam int QUEUE_DEPTH_DEF = 32;

  // request queue between front and back
  localparam int CMD_FIFO_DEPTH = 2;
  localparam int CMD_PTR_W      = $clog2(CMD_FIFO_DEPTH);
  localparam int CMD_CNT_W      = $clog2(CMD_FIFO_DEPTH + 1);

  // bus timing register
  localparam int          PERIOD_W          = 16;
  localparam logic [15:0] HALF_PERIOD_RESET = 16'd10;
  localparam int          CFG_ADDR_W        = 3;
  localparam int          CFG_INDEX_W       = CFG_ADDR_W - 2;
  localparam logic [CFG_INDEX_W-1:0] REG_HALF_PERIOD = '0;

  localparam int BITS_PER_BYTE = 8;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_PUSH  = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_NACK   = 2'd1,
    STAT_REJECT = 2'd2
  } status_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_S_SDA_HI,
    ST_S_SCL_HI,
    ST_S_SDA_LO,
    ST_S_SCL_LO,
    ST_T_SETUP,
    ST_T_SCL_HI,
    ST_T_SCL_LO,
    ST_A_SCL_HI,
    ST_A_SCL_LO,
    ST_R_SCL_HI,
    ST_R_SCL_LO,
    ST_K_SETUP,
    ST_K_SCL_HI,
    ST_K_SCL_LO,
    ST_P_SDA_LO,
    ST_P_SCL_HI,
    ST_P_SDA_HI
  } step_t;

  typedef enum logic [2:0] {
    SEC_ADDR_W,
    SEC_REG,
    SEC_DATA,
    SEC_ADDR_R,
    SEC_RECV
  } section_t;

  // classified request as held in the queue
  typedef struct packed {
    op_t        op;
    logic [6:0] addr;
    logic [5:0] regc;
    logic [5:0] datc;
    logic [6:0] xfer_len;
    logic [7:0] value;
    logic       sda;
  } cmd_t;

  // one result request
  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       drv;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       done;
    status_t    status;
    logic       busy;
  } result_t;

endpackage

`default_nettype wire

/* hdl/i2cm_front.sv */
// front end: accepts requests, classifies them and queues them for the sequencer
// depends on i2cm_pkg
`default_nettype none

module i2cm_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [1:0]       operation,
  input  wire logic [6:0]       slave_address,
  input  wire logic [5:0]       reg_count,
  input  wire logic [5:0]       data_count,
  input  wire logic [7:0]       byte_value,
  input  wire logic             sda_in,
  output logic                  cmd_valid,
  output i2cm_pkg::cmd_t        cmd,
  input  wire logic             cmd_pop
);
  import i2cm_pkg::*;

  cmd_t                 fifo_mem [CMD_FIFO_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr;
  logic [CMD_PTR_W-1:0] rd_ptr;
  logic [CMD_CNT_W-1:0] count;
  logic [CMD_CNT_W-1:0] count_next;
  cmd_t                 cmd_in;
  logic                 push;

  // classify the incoming request
  always_comb begin
    cmd_in.op       = op_t'(operation);
    cmd_in.addr     = slave_address;
    cmd_in.regc     = reg_count;
    cmd_in.datc     = data_count;
    cmd_in.xfer_len = {1'b0, reg_count} + {1'b0, data_count};
    cmd_in.value    = byte_value;
    cmd_in.sda      = sda_in;
  end

  assign in_ready  = (count != CMD_CNT_W'(CMD_FIFO_DEPTH));
  assign push      = in_valid && in_ready;
  assign cmd_valid = (count != '0);
  assign cmd       = fifo_mem[rd_ptr];

  // fill count
  always_comb begin
    case ({push, cmd_pop})
      2'b10:   count_next = count + CMD_CNT_W'(1);
      2'b01:   count_next = count - CMD_CNT_W'(1);
      default: count_next = count;
    endcase
  end

  // queue pointers, depth is a power of two so they wrap on their own
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= wr_ptr + CMD_PTR_W'(1);
      end
      if (cmd_pop) begin
        rd_ptr <= rd_ptr + CMD_PTR_W'(1);
      end
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_ptr] <= cmd_in;
    end
  end

endmodule

`default_nettype wire

/* hdl/i2cm_back.sv */
// back end: byte queue memory, bus phase sequencer and result register
// depends on i2cm_pkg
`default_nettype none

module i2cm_back #(
  parameter int QUEUE_DEPTH = i2cm_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cmd_valid,
  input  wire i2cm_pkg::cmd_t                  cmd,
  output logic                                 cmd_pop,
  input  wire logic [i2cm_pkg::PERIOD_W-1:0]   half_period_ticks,
  output logic                                 res_valid,
  input  wire logic                            res_ready,
  output i2cm_pkg::result_t                    res
);
  import i2cm_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int PW = $clog2(QUEUE_DEPTH + 1);
  localparam int CW = (PW > 7) ? PW : 7;

  // byte queue memory
  logic [7:0]    byte_queue [QUEUE_DEPTH];
  logic [7:0]    rd_data;
  logic          mem_we;
  logic [AW-1:0] wr_addr;

  // sequencer state
  step_t                step, step_next;
  section_t             section, section_next;
  logic [PERIOD_W-1:0]  phase_counter, phase_counter_next;
  logic [3:0]           bit_index, bit_index_next;
  logic [7:0]           shift_register, shift_register_next;
  logic [5:0]           byte_index, byte_index_next;
  logic [6:0]           target_address, target_address_next;
  logic                 is_read, is_read_next;
  logic [5:0]           register_bytes, register_bytes_next;
  logic [5:0]           data_bytes, data_bytes_next;
  logic                 scl, scl_next;
  logic                 sda, sda_next;
  logic                 drv, drv_next;
  logic                 slave_nack, slave_nack_next;
  logic [PW-1:0]        queue_fill, queue_fill_next;
  logic [PW-1:0]        tx_ptr, tx_ptr_next;

  logic                 fire;
  result_t              res_next;

  assign fire    = cmd_valid && (!res_valid || res_ready);
  assign cmd_pop = fire;

  // next state and result for one request
  always_comb begin
    logic                busy;
    logic [PERIOD_W-1:0] limit;
    logic [PERIOD_W-1:0] pc_inc;
    logic [3:0]          bit_inc;
    logic [5:0]          idx;
    logic                start_ok;
    logic                do_start;
    logic                do_tx;
    logic                do_rx;
    logic                do_stop;
    logic                do_finish;
    logic                take_queue;
    logic                data_check;
    status_t             fin_code;
    logic [7:0]          tx_byte;

    step_next           = step;
    section_next        = section;
    phase_counter_next  = phase_counter;
    bit_index_next      = bit_index;
    shift_register_next = shift_register;
    byte_index_next     = byte_index;
    target_address_next = target_address;
    is_read_next        = is_read;
    register_bytes_next = register_bytes;
    data_bytes_next     = data_bytes;
    scl_next            = scl;
    sda_next            = sda;
    drv_next            = drv;
    slave_nack_next     = slave_nack;
    queue_fill_next     = queue_fill;
    tx_ptr_next         = tx_ptr;
    mem_we              = 1'b0;
    wr_addr             = queue_fill[AW-1:0];

    res_next.read_byte  = '0;
    res_next.read_valid = 1'b0;
    res_next.done       = 1'b0;
    res_next.status     = STAT_OK;

    busy       = (step != ST_IDLE);
    limit      = (half_period_ticks == '0) ? PERIOD_W'(1) : half_period_ticks;
    pc_inc     = phase_counter + PERIOD_W'(1);
    bit_inc    = bit_index + 4'd1;
    idx        = '0;
    start_ok   = 1'b0;
    do_start   = 1'b0;
    do_tx      = 1'b0;
    do_rx      = 1'b0;
    do_stop    = 1'b0;
    do_finish  = 1'b0;
    take_queue = 1'b0;
    data_check = 1'b0;
    fin_code   = STAT_OK;
    tx_byte    = '0;

    if (fire) begin
      if (cmd.op == OP_TICK) begin
        // a tick advances the current phase, and ends it at the limit
        if (busy) begin
          phase_counter_next = pc_inc;
          if (pc_inc >= limit) begin
            phase_counter_next = '0;
            unique case (step)
              ST_S_SDA_HI: begin
                step_next = ST_S_SCL_HI;
                scl_next = 1'b1; sda_next = 1'b1; drv_next = 1'b1;
              end
              ST_S_SCL_HI: begin
                step_next = ST_S_SDA_LO;
                scl_next = 1'b1; sda_next = 1'b0; drv_next = 1'b1;
              end
              ST_S_SDA_LO: begin
                step_next = ST_S_SCL_LO;
                scl_next = 1'b0; sda_next = 1'b0; drv_next = 1'b1;
              end
              ST_S_SCL_LO: begin
                // address byte with the direction bit
                do_tx   = 1'b1;
                tx_byte = {target_address, (section == SEC_ADDR_R)};
              end
              ST_T_SETUP: begin
                step_next = ST_T_SCL_HI;
                scl_next  = 1'b1;
              end
              ST_T_SCL_HI: begin
                step_next = ST_T_SCL_LO;
                scl_next  = 1'b0;
              end
              ST_T_SCL_LO: begin
                shift_register_next = {shift_register[6:0], 1'b0};
                bit_index_next      = bit_inc;
                if (bit_inc < 4'(BITS_PER_BYTE)) begin
                  step_next = ST_T_SETUP;
                  scl_next = 1'b0; sda_next = shift_register[6]; drv_next = 1'b1;
                end else begin
                  step_next = ST_A_SCL_HI;
                  scl_next = 1'b1; sda_next = 1'b1; drv_next = 1'b0;
                end
              end
              ST_A_SCL_HI: begin
                slave_nack_next = cmd.sda;
                step_next = ST_A_SCL_LO;
                scl_next = 1'b0; sda_next = 1'b1; drv_next = 1'b1;
              end
              ST_A_SCL_LO: begin
                // after the acknowledge: finish on a nack, else next byte, repeated start, receive or stop
                if (slave_nack) begin
                  do_finish = 1'b1;
                  fin_code  = STAT_NACK;
                end else begin
                  unique case (section) inside
                    SEC_ADDR_W, SEC_REG: begin
                      idx = (section == SEC_ADDR_W) ? 6'd0 : byte_index + 6'd1;
                      section_next    = SEC_REG;
                      byte_index_next = idx;
                      if (idx < register_bytes) begin
                        take_queue = 1'b1;
                      end else if (is_read) begin
                        section_next = SEC_ADDR_R;
                        do_start     = 1'b1;
                      end else begin
                        section_next    = SEC_DATA;
                        byte_index_next = '0;
                        idx             = '0;
                        data_check      = 1'b1;
                      end
                    end
                    SEC_DATA: begin
                      idx             = byte_index + 6'd1;
                      byte_index_next = idx;
                      data_check      = 1'b1;
                    end
                    default: begin
                      section_next    = SEC_RECV;
                      byte_index_next = '0;
                      do_rx           = 1'b1;
                    end
                  endcase
                  if (data_check) begin
                    if (idx < data_bytes) begin
                      take_queue = 1'b1;
                    end else begin
                      do_stop = 1'b1;
                    end
                  end
                end
              end
              ST_R_SCL_HI: begin
                shift_register_next = {shift_register[6:0], cmd.sda};
                bit_index_next      = bit_inc;
                if (bit_inc >= 4'(BITS_PER_BYTE)) begin
                  res_next.read_byte  = {shift_register[6:0], cmd.sda};
                  res_next.read_valid = 1'b1;
                end
                step_next = ST_R_SCL_LO;
                scl_next = 1'b0; sda_next = 1'b1; drv_next = 1'b0;
              end
              ST_R_SCL_LO: begin
                if (bit_index < 4'(BITS_PER_BYTE)) begin
                  step_next = ST_R_SCL_HI;
                  scl_next = 1'b1; sda_next = 1'b1; drv_next = 1'b0;
                end else begin
                  // acknowledge, or not-acknowledge on the last byte
                  step_next = ST_K_SETUP;
                  scl_next = 1'b0;
                  sda_next = (({1'b0, byte_index} + 7'd1) >= {1'b0, data_bytes});
                  drv_next = 1'b1;
                end
              end
              ST_K_SETUP: begin
                step_next = ST_K_SCL_HI;
                scl_next  = 1'b1;
              end
              ST_K_SCL_HI: begin
                step_next = ST_K_SCL_LO;
                scl_next  = 1'b0;
              end
              ST_K_SCL_LO: begin
                byte_index_next = byte_index + 6'd1;
                if ((byte_index + 6'd1) < data_bytes) begin
                  do_rx = 1'b1;
                end else begin
                  do_stop = 1'b1;
                end
              end
              ST_P_SDA_LO: begin
                step_next = ST_P_SCL_HI;
                scl_next = 1'b1; sda_next = 1'b0; drv_next = 1'b1;
              end
              ST_P_SCL_HI: begin
                step_next = ST_P_SDA_HI;
                scl_next = 1'b1; sda_next = 1'b1; drv_next = 1'b1;
              end
              ST_P_SDA_HI: begin
                do_finish = 1'b1;
                fin_code  = STAT_OK;
              end
              default: begin
                step_next = ST_IDLE;
              end
            endcase
          end
        end
      end else if (busy) begin
        res_next.status = STAT_REJECT;
      end else if (cmd.op == OP_PUSH) begin
        // append a byte to the queue, or reject it when the queue is full
        if (queue_fill < PW'(QUEUE_DEPTH)) begin
          mem_we          = 1'b1;
          queue_fill_next = queue_fill + PW'(1);
        end else begin
          res_next.status = STAT_REJECT;
        end
      end else begin
        // start a transaction after the length checks
        if (cmd.op == OP_READ) begin
          start_ok = (cmd.datc != '0) && (CW'(cmd.regc) <= CW'(queue_fill));
        end else begin
          start_ok = (CW'(cmd.xfer_len) <= CW'(queue_fill));
        end
        if (!start_ok) begin
          res_next.status = STAT_REJECT;
        end else begin
          target_address_next = cmd.addr;
          is_read_next        = (cmd.op == OP_READ);
          register_bytes_next = cmd.regc;
          data_bytes_next     = cmd.datc;
          byte_index_next     = '0;
          phase_counter_next  = '0;
          slave_nack_next     = 1'b0;
          tx_ptr_next         = '0;
          section_next = ((cmd.op == OP_READ) && (cmd.regc == '0)) ? SEC_ADDR_R : SEC_ADDR_W;
          do_start = 1'b1;
        end
      end
    end

    // queued bytes go out in order, the read port is kept one byte ahead
    if (take_queue) begin
      do_tx       = 1'b1;
      tx_byte     = rd_data;
      tx_ptr_next = tx_ptr + PW'(1);
    end

    // phase entry actions
    if (do_start) begin
      step_next = ST_S_SDA_HI;
      sda_next  = 1'b1;
      drv_next  = 1'b1;
    end
    if (do_tx) begin
      shift_register_next = tx_byte;
      bit_index_next      = '0;
      step_next           = ST_T_SETUP;
      scl_next            = 1'b0;
      sda_next            = tx_byte[7];
      drv_next            = 1'b1;
    end
    if (do_rx) begin
      shift_register_next = '0;
      bit_index_next      = '0;
      step_next           = ST_R_SCL_HI;
      scl_next = 1'b1; sda_next = 1'b1; drv_next = 1'b0;
    end
    if (do_stop) begin
      step_next = ST_P_SDA_LO;
      scl_next = 1'b0; sda_next = 1'b0; drv_next = 1'b1;
    end
    if (do_finish) begin
      step_next       = ST_IDLE;
      queue_fill_next = '0;
      res_next.done   = 1'b1;
      res_next.status = fin_code;
    end

    res_next.scl  = scl_next;
    res_next.sda  = sda_next;
    res_next.drv  = drv_next;
    res_next.busy = (step_next != ST_IDLE);
  end

  // sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      step           <= ST_IDLE;
      section        <= SEC_ADDR_W;
      phase_counter  <= '0;
      bit_index      <= '0;
      shift_register <= '0;
      byte_index     <= '0;
      target_address <= '0;
      is_read        <= 1'b0;
      register_bytes <= '0;
      data_bytes     <= '0;
      scl            <= 1'b1;
      sda            <= 1'b1;
      drv            <= 1'b1;
      slave_nack     <= 1'b0;
      queue_fill     <= '0;
      tx_ptr         <= '0;
    end else begin
      step           <= step_next;
      section        <= section_next;
      phase_counter  <= phase_counter_next;
      bit_index      <= bit_index_next;
      shift_register <= shift_register_next;
      byte_index     <= byte_index_next;
      target_address <= target_address_next;
      is_read        <= is_read_next;
      register_bytes <= register_bytes_next;
      data_bytes     <= data_bytes_next;
      scl            <= scl_next;
      sda            <= sda_next;
      drv            <= drv_next;
      slave_nack     <= slave_nack_next;
      queue_fill     <= queue_fill_next;
      tx_ptr         <= tx_ptr_next;
    end
  end

  // byte queue: one write port, registered read at the transmit pointer
  always_ff @(posedge clk) begin
    if (mem_we) begin
      byte_queue[wr_addr] <= cmd.value;
    end
    rd_data <= byte_queue[tx_ptr[AW-1:0]];
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (fire) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res <= res_next;
    end
  end

endmodule

`default_nettype wire

/* hdl/i2c_master_transaction_engine.sv */
// top level of the i2c master transaction engine: timing register port,
// front end, request queue and sequencer; depends on i2cm_pkg, i2cm_front, i2cm_back
//
// Usage: each input request is an operation (tick, queue byte, start write,
// start read) with its fields; every request gives exactly one result with
// the bus line levels after it, any received byte, the done flag, status and
// busy. Both channels use valid/ready. Ticks pace the bus: one bus phase
// lasts half_period_ticks ticks (0 behaves as 1), set through the register
// at byte address 0 of the APB port while the block is idle.
// Throughput is one request per clock while the result channel is not
// stalled. A request is written into the two-entry request queue and then
// stepped by the sequencer in the back end into the result register, from
// which its result is offered. When the receiver stalls the result holds,
// the queue fills and in_ready drops after two more requests.
// Reset clears the sequencer to idle, empties the byte queue count and the
// request queue, and drives both bus lines high; half_period_ticks returns
// to 10. The byte memory needs no clearing pass.
`default_nettype none

module i2c_master_transaction_engine #(
  parameter int QUEUE_DEPTH = i2cm_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // configuration port
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [i2cm_pkg::CFG_ADDR_W-1:0]   paddr,
  input  wire logic [31:0]                       pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready,
  // request channel
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [1:0]                        operation,
  input  wire logic [6:0]                        slave_address,
  input  wire logic [5:0]                        reg_count,
  input  wire logic [5:0]                        data_count,
  input  wire logic [7:0]                        byte_value,
  input  wire logic                              sda_in,
  // result channel
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic                                   scl_level,
  output logic                                   sda_level,
  output logic                                   sda_drive,
  output logic [7:0]                             read_byte,
  output logic                                   read_valid,
  output logic                                   done_res,
  output logic [1:0]                             status,
  output logic                                   busy_res
);
  import i2cm_pkg::*;

  logic [PERIOD_W-1:0]    half_period_ticks;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic                   cfg_write;
  logic                   cmd_valid;
  logic                   cmd_pop;
  cmd_t                   cmd;
  result_t                res;

  // timing register
  assign pready    = 1'b1;
  assign cfg_index = paddr[CFG_ADDR_W-1:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period_ticks <= HALF_PERIOD_RESET;
    end else if (cfg_write && (cfg_index == REG_HALF_PERIOD)) begin
      half_period_ticks <= pwdata[PERIOD_W-1:0];
    end
  end

  always_comb begin
    if (cfg_index == REG_HALF_PERIOD) begin
      prdata = {{(32 - PERIOD_W){1'b0}}, half_period_ticks};
    end else begin
      prdata = '0;
    end
  end

  i2cm_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .operation     (operation),
    .slave_address (slave_address),
    .reg_count     (reg_count),
    .data_count    (data_count),
    .byte_value    (byte_value),
    .sda_in        (sda_in),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_pop       (cmd_pop)
  );

  i2cm_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk               (clk),
    .rst               (rst),
    .cmd_valid         (cmd_valid),
    .cmd               (cmd),
    .cmd_pop           (cmd_pop),
    .half_period_ticks (half_period_ticks),
    .res_valid         (out_valid),
    .res_ready         (out_ready),
    .res               (res)
  );

  // result fields
  assign scl_level  = res.scl;
  assign sda_level  = res.sda;
  assign sda_drive  = res.drv;
  assign read_byte  = res.read_byte;
  assign read_valid = res.read_valid;
  assign done_res   = res.done;
  assign status     = res.status;
  assign busy_res   = res.busy;

  // a finished transaction leaves the engine idle
  assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> !busy_res)
    else $error("transaction ended but engine still busy");

  // a received byte is reported with the data line released and clock low
  assert property (@(posedge clk) disable iff (rst)
    out_valid && read_valid |-> !sda_drive && !scl_level)
    else $error("read byte reported outside a receive phase");

  // a rejected request never ends a transaction
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == STAT_REJECT) |-> !done_res)
    else $error("rejected request flagged as done");

  // a full request queue always holds a request to pop
  assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> cmd_valid)
    else $error("request queue full but nothing to pop");

endmodule

`default_nettype wire
